### src/event_time_priority_scheduler_assert.svh
// Assertion macros for the event time priority scheduler.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef EVENT_TIME_PRIORITY_SCHEDULER_ASSERT_SVH
`define EVENT_TIME_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define ETS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
`define ETS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define ETS_ASSERT_SAME(label, ante, cons)
`define ETS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/ets_pkg.sv
// Shared types and codes for the event time priority scheduler.
// No dependencies; used by ets_cell and event_time_priority_scheduler.
package ets_pkg;

    // Operation codes of an input word.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_WAKE   = 3'd0,
        ST_QUEUED = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

### src/ets_cell.sv
// One cell of the sorted queue row: holds a single (time, id) entry.
// Depends on ets_pkg for the broadcast command type.
module ets_cell #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16,
    parameter int INDEX   = 0
) (
    input  logic                         clk,
    input  ets_pkg::cell_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [31:0]                  new_time,
    input  logic [ID_BITS-1:0]           new_id,
    input  logic                         left_before,
    input  logic [31:0]                  left_time,
    input  logic [ID_BITS-1:0]           left_id,
    input  logic [31:0]                  right_time,
    input  logic [ID_BITS-1:0]           right_id,
    output logic                         ahead,
    output logic [31:0]                  entry_time,
    output logic [ID_BITS-1:0]           entry_id
);
    import ets_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]        time_reg;
    logic [31:0]        time_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               occupied;

    // The cell is occupied when its position lies below the fill count.
    assign occupied = CW'(INDEX) < count;

    // The new entry goes ahead of this one when the cell is free or the time
    // is strictly smaller; equal times go by the smaller id, equal entries keep arrival order.
    always_comb
    begin
        ahead = !occupied || (new_time < time_reg) ||
                ((new_time == time_reg) && (new_id < id_reg));
    end

    // Insert shifts entries toward the tail, removal shifts toward the head.
    always_comb
    begin
        time_next = time_reg;
        id_next   = id_reg;
        if (ctrl.push && ahead)
        begin
            if (left_before)
            begin
                time_next = new_time;
                id_next   = new_id;
            end
            else
            begin
                time_next = new_time;
                id_next   = new_id;
            end
            if (left_before)
            begin
                time_next = left_time;
                id_next   = left_id;
            end
        end
        else if (ctrl.pop)
        begin
            time_next = right_time;
            id_next   = right_id;
        end
    end

    // Entry storage needs no reset: it is only read below the fill count.
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign entry_time = time_reg;
    assign entry_id   = id_reg;

endmodule

### src/event_time_priority_scheduler.sv
// Top level of the event time priority scheduler: control, time keeping and
// the row of ets_cell entries. Depends on ets_pkg and the assertion header.
//
// Usage:
// - Input channel (in_valid/in_ready): one word per item. operation selects a
//   push of (wake_time, requester_id) or a pop of the earliest entry.
// - Output channel (out_valid/out_ready): exactly one result word per item
//   with status, wake_id, accepted and time_now.
// - Config channel (cfg_valid/cfg_ready/cfg_data) writes end_time; it is
//   always ready; the user must write it only while idle (not enforced).
// - The result is registered and valid in the cycle after input accept. Throughput is one
//   item per cycle while the receiver takes results, set by the cell row in
//   which every cell compares its entry with the new key in the same cycle.
// - When the receiver stalls, the result stays in the output register and
//   in_ready drops until it is taken; no word is lost.
// - Reset empties the queue, clears the time and end_time to zero and drops
//   out_valid. Entry contents are not cleared; the fill count masks them.
module event_time_priority_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] wake_time,
    input  logic [15:0] requester_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] wake_id,
    output logic        accepted,
    output logic [31:0] time_now
);
    import ets_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [31:0]        sim_time_reg;
    logic [31:0]        sim_time_next;
    logic [31:0]        end_time_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [15:0]        wake_id_reg;
    logic [15:0]        wake_id_next;
    logic               accepted_reg;
    logic               accepted_next;
    logic [31:0]        time_now_reg;
    logic               in_fire;
    cell_ctrl_t         ctrl;
    logic [ID_BITS-1:0] new_id;

    logic [31:0]        cell_time  [QUEUE_DEPTH];
    logic [ID_BITS-1:0] cell_id    [QUEUE_DEPTH];
    logic               cell_ahead [QUEUE_DEPTH];

    // Handshakes: a result waiting in the output register holds off input.
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign new_id    = ID_BITS'(requester_id);

    // Decide the item's effect and its result word.
    always_comb
    begin
        ctrl          = '0;
        count_next    = count_reg;
        sim_time_next = sim_time_reg;
        status_next   = ST_DONE;
        wake_id_next  = '0;
        accepted_next = 1'b0;
        if (operation == OP_PUSH)
        begin
            priority if (sim_time_reg > end_time_reg)
            begin
                status_next = ST_DONE;
            end
            else if (count_reg == CW'(QUEUE_DEPTH))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                ctrl.push   = in_fire;
                count_next  = count_reg + 1'b1;
                status_next = ST_QUEUED;
            end
        end
        else
        begin
            priority if (sim_time_reg >= end_time_reg)
            begin
                status_next = ST_DONE;
            end
            else if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                ctrl.pop     = in_fire;
                count_next   = count_reg - 1'b1;
                wake_id_next = 16'(cell_id[0]);
                if (sim_time_reg <= cell_time[0])
                begin
                    sim_time_next = cell_time[0];
                    accepted_next = 1'b1;
                end
                status_next = (sim_time_next < end_time_reg) ? ST_WAKE : ST_DONE;
            end
        end
    end

    // Row of cells; cell zero holds the earliest entry.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic               lb;
        logic [31:0]        lt;
        logic [ID_BITS-1:0] li;
        logic [31:0]        rt;
        logic [ID_BITS-1:0] ri;

        if (i == 0)
        begin : g_head
            assign lb = 1'b0;
            assign lt = cell_time[i];
            assign li = cell_id[i];
        end
        else
        begin : g_mid
            assign lb = cell_ahead[i-1];
            assign lt = cell_time[i-1];
            assign li = cell_id[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign rt = cell_time[i];
            assign ri = cell_id[i];
        end
        else
        begin : g_body
            assign rt = cell_time[i+1];
            assign ri = cell_id[i+1];
        end

        ets_cell #(
            .DEPTH   (QUEUE_DEPTH),
            .ID_BITS (ID_BITS),
            .INDEX   (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .new_time    (wake_time),
            .new_id      (new_id),
            .left_before (lb),
            .left_time   (lt),
            .left_id     (li),
            .right_time  (rt),
            .right_id    (ri),
            .ahead       (cell_ahead[i]),
            .entry_time  (cell_time[i]),
            .entry_id    (cell_id[i])
        );
    end

    // Control state: fill count, current time, end time, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sim_time_reg  <= '0;
            end_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                end_time_reg <= cfg_data;
            end
            if (in_fire)
            begin
                count_reg     <= count_next;
                sim_time_reg  <= sim_time_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg   <= status_next;
            wake_id_reg  <= wake_id_next;
            accepted_reg <= accepted_next;
            time_now_reg <= sim_time_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign wake_id   = wake_id_reg;
    assign accepted  = accepted_reg;
    assign time_now  = time_now_reg;

    // Checks on the queue bookkeeping and the time keeper.
`include "event_time_priority_scheduler_assert.svh"
    `ETS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `ETS_ASSERT_NEXT(a_push_grows, in_fire && ctrl.push, count_reg == $past(count_reg) + 1'b1)
    `ETS_ASSERT_NEXT(a_time_monotone, 1'b1, sim_time_reg >= $past(sim_time_reg))

endmodule
